@@ rtl/core/pol_pkg.sv @@
package pol_pkg;

  // Ring geometry
  localparam int CAPACITY = 64;
  localparam int SLOT_W   = $clog2(CAPACITY);
  localparam int COUNT_W  = 7;
  localparam int WALK_W   = $clog2(CAPACITY + 2);
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 7;
  localparam int MODE_W   = 2;
  localparam int STATUS_W = 2;

  // Free-slot search: groups of eight slots, registered per group
  localparam int GROUP   = 8;
  localparam int GROUPS  = CAPACITY / GROUP;
  localparam int GROUP_W = $clog2(GROUP);
  localparam int GSEL_W  = SLOT_W - GROUP_W;

  typedef enum logic [MODE_W-1:0] {
    MODE_APPEND,
    MODE_INSERT,
    MODE_DELETE,
    MODE_DUMP
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK,
    ST_INVALID,
    ST_FULL,
    ST_EMPTY
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_COMMIT,
    S_COMMIT2,
    S_RESP,
    S_DUMP
  } state_t;

  typedef struct packed {
    logic              alloc;
    logic [SLOT_W-1:0] alloc_slot;
    logic              rel;
    logic [SLOT_W-1:0] rel_slot;
  } free_ctl_t;

  typedef struct packed {
    logic              any;
    logic [SLOT_W-1:0] low;
  } free_stat_t;

  typedef struct packed {
    logic              re;
    logic [SLOT_W-1:0] raddr;
    logic              we;
    logic [SLOT_W-1:0] waddr;
    logic [SLOT_W-1:0] wdata;
  } link_cmd_t;

  typedef struct packed {
    logic               re;
    logic [SLOT_W-1:0]  raddr;
    logic               we;
    logic [SLOT_W-1:0]  waddr;
    logic [VALUE_W-1:0] wdata;
  } elem_cmd_t;

endpackage

@@ rtl/core/pol_req_if.sv @@
interface pol_req_if;
  logic                                valid;
  logic                                ready;
  logic [pol_pkg::MODE_W-1:0]          mode;
  logic signed [pol_pkg::VALUE_W-1:0]  value;
  logic [pol_pkg::POS_W-1:0]           position;

  modport source (output valid, output mode, output value, output position, input ready);
  modport sink   (input valid, input mode, input value, input position, output ready);
endinterface

@@ rtl/core/pol_rsp_if.sv @@
interface pol_rsp_if;
  logic                                valid;
  logic                                ready;
  logic signed [pol_pkg::VALUE_W-1:0]  value_out;
  logic [pol_pkg::STATUS_W-1:0]        status;
  logic [pol_pkg::COUNT_W-1:0]         element_count;
  logic                                last;

  modport source (output valid, output value_out, output status, output element_count,
                  output last, input ready);
  modport sink   (input valid, input value_out, input status, input element_count,
                  input last, output ready);
endinterface

@@ rtl/core/positional_ordered_list.sv @@
// Channel  Dir  Payload                                        Transfer
// req      in   mode[1:0], value[31:0] signed, position[6:0]   valid && ready
// rsp      out  value_out[31:0] signed, status[1:0],
//               element_count[6:0], last                       valid && ready
//
// One operation at a time. Append, insert and delete walk the ring one link per
// cycle through the single read port of the link memory, then write back in
// S_COMMIT and, for an insert into a non-empty list, also in S_COMMIT2. A dump
// reads one element per cycle off the element memory read port; errors go
// straight to the response.
// Reset is synchronous; slot tracking lives in flip-flops, so no clearing pass
// runs. A stalled rsp holds its item and pauses the dump.
module positional_ordered_list (
  input  logic      clk,
  input  logic      rst,
  pol_req_if.sink   req,
  pol_rsp_if.source rsp
);

  pol_pkg::link_cmd_t            link_cmd;
  pol_pkg::elem_cmd_t            elem_cmd;
  pol_pkg::free_ctl_t            free_ctl;
  pol_pkg::free_stat_t           free_stat;
  logic [pol_pkg::SLOT_W-1:0]    link_rdata;
  logic [pol_pkg::VALUE_W-1:0]   elem_rdata;

  // Next-link store
  pol_ram #(
    .WIDTH (pol_pkg::SLOT_W),
    .DEPTH (pol_pkg::CAPACITY)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_cmd.we),
    .waddr (link_cmd.waddr),
    .wdata (link_cmd.wdata),
    .re    (link_cmd.re),
    .raddr (link_cmd.raddr),
    .rdata (link_rdata)
  );

  // Element value store
  pol_ram #(
    .WIDTH (pol_pkg::VALUE_W),
    .DEPTH (pol_pkg::CAPACITY)
  ) u_elem_ram (
    .clk   (clk),
    .we    (elem_cmd.we),
    .waddr (elem_cmd.waddr),
    .wdata (elem_cmd.wdata),
    .re    (elem_cmd.re),
    .raddr (elem_cmd.raddr),
    .rdata (elem_rdata)
  );

  pol_free u_free (
    .clk  (clk),
    .rst  (rst),
    .ctl  (free_ctl),
    .stat (free_stat)
  );

  pol_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .rsp        (rsp),
    .link_cmd   (link_cmd),
    .link_rdata (link_rdata),
    .elem_cmd   (elem_cmd),
    .elem_rdata (elem_rdata),
    .free_ctl   (free_ctl),
    .free_stat  (free_stat)
  );

endmodule

@@ rtl/core/pol_ram.sv @@
module pol_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read; hold the last word while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/pol_free.sv @@
module pol_free (
  input  logic                clk,
  input  logic                rst,
  input  pol_pkg::free_ctl_t  ctl,
  output pol_pkg::free_stat_t stat
);

  logic [pol_pkg::CAPACITY-1:0] free_map;
  logic                         grp_any      [pol_pkg::GROUPS];
  logic [pol_pkg::GROUP_W-1:0]  grp_low      [pol_pkg::GROUPS];
  logic                         grp_any_next [pol_pkg::GROUPS];
  logic [pol_pkg::GROUP_W-1:0]  grp_low_next [pol_pkg::GROUPS];

  // Track free slots: clear on allocation, set on release
  always_ff @(posedge clk) begin
    if (rst) begin
      free_map <= '1;
    end else begin
      if (ctl.alloc) begin
        free_map[ctl.alloc_slot] <= 1'b0;
      end
      if (ctl.rel) begin
        free_map[ctl.rel_slot] <= 1'b1;
      end
    end
  end

  // Find the lowest free slot of each group
  always_comb begin
    for (int g = 0; g < pol_pkg::GROUPS; g++) begin
      grp_any_next[g] = |free_map[g*pol_pkg::GROUP +: pol_pkg::GROUP];
      grp_low_next[g] = '0;
      for (int b = pol_pkg::GROUP - 1; b >= 0; b--) begin
        if (free_map[g*pol_pkg::GROUP + b]) begin
          grp_low_next[g] = pol_pkg::GROUP_W'(b);
        end
      end
    end
  end

  // Register the per-group result
  always_ff @(posedge clk) begin
    for (int g = 0; g < pol_pkg::GROUPS; g++) begin
      grp_any[g] <= grp_any_next[g];
      grp_low[g] <= grp_low_next[g];
    end
  end

  // Pick the lowest group that has a free slot
  always_comb begin
    stat.any = 1'b0;
    stat.low = '0;
    for (int g = pol_pkg::GROUPS - 1; g >= 0; g--) begin
      if (grp_any[g]) begin
        stat.any = 1'b1;
        stat.low = {pol_pkg::GSEL_W'(g), grp_low[g]};
      end
    end
  end

endmodule

@@ rtl/core/pol_seq.sv @@
module pol_seq (
  input  logic                          clk,
  input  logic                          rst,
  pol_req_if.sink                       req,
  pol_rsp_if.source                     rsp,
  output pol_pkg::link_cmd_t            link_cmd,
  input  logic [pol_pkg::SLOT_W-1:0]    link_rdata,
  output pol_pkg::elem_cmd_t            elem_cmd,
  input  logic [pol_pkg::VALUE_W-1:0]   elem_rdata,
  output pol_pkg::free_ctl_t            free_ctl,
  input  pol_pkg::free_stat_t           free_stat
);

  pol_pkg::state_t state, state_next;

  // Control state
  logic [pol_pkg::COUNT_W-1:0] count;
  logic [pol_pkg::SLOT_W-1:0]  head;
  logic                        fetched;
  logic                        pend;
  logic [pol_pkg::WALK_W-1:0]  walk_n;
  logic                        out_valid;

  // Operation registers
  logic                         is_ins;
  logic                         empty_ins;
  logic                         pos_one;
  pol_pkg::status_t             stat;
  logic [pol_pkg::VALUE_W-1:0]  val;
  logic [pol_pkg::WALK_W-1:0]   walk_end;
  logic [pol_pkg::SLOT_W-1:0]   ptr;
  logic [pol_pkg::SLOT_W-1:0]   prev1;
  logic [pol_pkg::SLOT_W-1:0]   prev2;
  logic [pol_pkg::SLOT_W-1:0]   far;
  logic [pol_pkg::SLOT_W-1:0]   slot;

  // Output register
  logic [pol_pkg::VALUE_W-1:0]  out_value;
  pol_pkg::status_t             out_status;
  logic [pol_pkg::COUNT_W-1:0]  out_count;
  logic                         out_last;

  // Decode
  pol_pkg::mode_t               req_mode;
  logic                         accept;
  logic [pol_pkg::POS_W-1:0]    ins_pos;
  logic [pol_pkg::POS_W-1:0]    pos_sel;
  logic [pol_pkg::POS_W-1:0]    count_p1;
  logic [pol_pkg::POS_W-1:0]    steps;
  logic                         dec_ins;
  pol_pkg::status_t             dec_status;
  pol_pkg::state_t              dec_state;

  logic [pol_pkg::SLOT_W-1:0]   cur_ptr;
  logic                         walk_done;
  logic                         can_load;
  logic                         dump_last;
  logic                         rd_issue;
  logic                         out_load;

  assign req_mode  = pol_pkg::mode_t'(req.mode);
  assign req.ready = (state == pol_pkg::S_IDLE) && !rst;
  assign accept    = req.valid && req.ready;

  assign cur_ptr   = fetched ? link_rdata : ptr;
  assign walk_done = (walk_n == walk_end);
  assign can_load  = !out_valid || rsp.ready;
  assign dump_last = (walk_n == pol_pkg::WALK_W'(count - 1'b1));

  // Classify the incoming operation and size its walk
  always_comb begin
    count_p1   = pol_pkg::POS_W'(count) + 1'b1;
    ins_pos    = (req_mode == pol_pkg::MODE_APPEND) ? count_p1 : req.position;
    dec_ins    = (req_mode == pol_pkg::MODE_APPEND) || (req_mode == pol_pkg::MODE_INSERT);
    pos_sel    = dec_ins ? ins_pos : req.position;
    steps      = (pos_sel == 1) ? pol_pkg::POS_W'(count - 1'b1) : pos_sel - 2'd2;
    dec_status = pol_pkg::ST_OK;
    dec_state  = pol_pkg::S_RESP;
    unique case (req_mode)
      pol_pkg::MODE_APPEND, pol_pkg::MODE_INSERT: begin
        if (count == pol_pkg::COUNT_W'(pol_pkg::CAPACITY)) begin
          dec_status = pol_pkg::ST_FULL;
        end else if (ins_pos == 0 || ins_pos > count_p1) begin
          dec_status = pol_pkg::ST_INVALID;
        end else if (count == 0) begin
          dec_state = pol_pkg::S_COMMIT;
        end else begin
          dec_state = pol_pkg::S_WALK;
        end
      end
      pol_pkg::MODE_DELETE: begin
        if (count == 0) begin
          dec_status = pol_pkg::ST_EMPTY;
        end else if (req.position == 0 || req.position > pol_pkg::POS_W'(count)) begin
          dec_status = pol_pkg::ST_INVALID;
        end else begin
          dec_state = pol_pkg::S_WALK;
        end
      end
      pol_pkg::MODE_DUMP: begin
        if (count == 0) begin
          dec_status = pol_pkg::ST_EMPTY;
        end else begin
          dec_state = pol_pkg::S_DUMP;
        end
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pol_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and memory strobes
  always_comb begin
    state_next     = state;
    link_cmd       = '0;
    elem_cmd       = '0;
    free_ctl       = '0;
    rd_issue       = 1'b0;
    out_load       = 1'b0;
    link_cmd.raddr = cur_ptr;
    elem_cmd.raddr = cur_ptr;
    elem_cmd.waddr = free_stat.low;
    elem_cmd.wdata = val;
    unique case (state)
      pol_pkg::S_IDLE: begin
        if (accept) begin
          state_next = dec_state;
        end
      end
      pol_pkg::S_WALK: begin
        if (walk_done) begin
          state_next = pol_pkg::S_COMMIT;
        end else begin
          link_cmd.re = 1'b1;
        end
      end
      pol_pkg::S_COMMIT: begin
        link_cmd.we = 1'b1;
        if (is_ins) begin
          link_cmd.waddr      = empty_ins ? free_stat.low : prev1;
          link_cmd.wdata      = free_stat.low;
          elem_cmd.we         = 1'b1;
          free_ctl.alloc      = 1'b1;
          free_ctl.alloc_slot = free_stat.low;
          state_next          = empty_ins ? pol_pkg::S_RESP : pol_pkg::S_COMMIT2;
        end else begin
          link_cmd.waddr    = prev2;
          link_cmd.wdata    = far;
          free_ctl.rel      = 1'b1;
          free_ctl.rel_slot = prev1;
          state_next        = pol_pkg::S_RESP;
        end
      end
      pol_pkg::S_COMMIT2: begin
        link_cmd.we    = 1'b1;
        link_cmd.waddr = slot;
        link_cmd.wdata = far;
        state_next     = pol_pkg::S_RESP;
      end
      pol_pkg::S_RESP: begin
        if (can_load) begin
          out_load   = 1'b1;
          state_next = pol_pkg::S_IDLE;
        end
      end
      pol_pkg::S_DUMP: begin
        if (!pend) begin
          rd_issue = 1'b1;
        end else if (can_load) begin
          out_load = 1'b1;
          if (dump_last) begin
            state_next = pol_pkg::S_IDLE;
          end else begin
            rd_issue = 1'b1;
          end
        end
        link_cmd.re = rd_issue;
        elem_cmd.re = rd_issue;
      end
      default: begin
        state_next = pol_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers: count, head, walk progress, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      head      <= '0;
      fetched   <= 1'b0;
      pend      <= 1'b0;
      walk_n    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        fetched <= 1'b0;
        pend    <= 1'b0;
        walk_n  <= '0;
      end
      // Advance the walk one link per cycle
      if (state == pol_pkg::S_WALK && !walk_done) begin
        fetched <= 1'b1;
        walk_n  <= walk_n + 1'b1;
      end
      // Update count and head on commit
      if (state == pol_pkg::S_COMMIT) begin
        if (is_ins) begin
          count <= count + 1'b1;
          if (empty_ins || pos_one) begin
            head <= free_stat.low;
          end
        end else begin
          count <= count - 1'b1;
          if (count == 1) begin
            head <= '0;
          end else if (pos_one) begin
            head <= far;
          end
        end
      end
      // Dump progress
      if (state == pol_pkg::S_DUMP) begin
        if (rd_issue) begin
          fetched <= 1'b1;
          pend    <= 1'b1;
        end
        if (out_load) begin
          walk_n <= walk_n + 1'b1;
          if (dump_last) begin
            pend <= 1'b0;
          end
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Operation and output payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      val       <= req.value;
      is_ins    <= dec_ins;
      empty_ins <= (count == 0);
      pos_one   <= (pos_sel == 1);
      stat      <= dec_status;
      walk_end  <= dec_ins ? pol_pkg::WALK_W'(steps) + 1'b1 : pol_pkg::WALK_W'(steps) + 2'd2;
      ptr       <= head;
    end
    if (state == pol_pkg::S_WALK) begin
      if (walk_done) begin
        far <= cur_ptr;
      end else begin
        ptr   <= cur_ptr;
        prev1 <= cur_ptr;
        prev2 <= prev1;
      end
    end
    if (state == pol_pkg::S_COMMIT) begin
      slot <= free_stat.low;
    end
    if (rd_issue) begin
      ptr <= cur_ptr;
    end
    if (out_load) begin
      out_count <= count;
      if (state == pol_pkg::S_DUMP) begin
        out_value  <= elem_rdata;
        out_status <= pol_pkg::ST_OK;
        out_last   <= dump_last;
      end else begin
        out_value  <= '0;
        out_status <= stat;
        out_last   <= 1'b1;
      end
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.value_out     = out_value;
  assign rsp.status        = out_status;
  assign rsp.element_count = out_count;
  assign rsp.last          = out_last;

  // An accepted transfer always leaves idle
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != pol_pkg::S_IDLE)
    else $error("accepted transfer did not start an operation");

  // The walk never runs past its end
  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    state == pol_pkg::S_WALK |-> walk_n <= walk_end)
    else $error("walk counter overran its end");

  // An insert commit always finds a free slot
  a_slot_free: assert property (@(posedge clk) disable iff (rst)
    (state == pol_pkg::S_COMMIT && is_ins) |-> free_stat.any)
    else $error("insert committed with no free slot");

  // The element count moves only after a commit
  a_count_commit: assert property (@(posedge clk) disable iff (rst)
    (count != $past(count)) |-> ($past(state) == pol_pkg::S_COMMIT))
    else $error("element count changed outside commit");

  // The count never exceeds capacity
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    out_load |=> out_count <= pol_pkg::COUNT_W'(pol_pkg::CAPACITY))
    else $error("element count above capacity");

endmodule

@@ verif/pol_list_checker.sv @@
`timescale 1ns / 1ps

// Watches both channels of the list block, keeps its own copy of the ordered
// list, and checks every response transfer against the oldest expected result.
module pol_list_checker (
  input  logic clk,
  input  logic rst,
  pol_req_if   req_mon,
  pol_rsp_if   rsp_mon,
  output int   fail_count,
  output int   pending,
  output int   result_count
);

  typedef struct packed {
    logic [pol_pkg::VALUE_W-1:0] value_out;
    pol_pkg::status_t            status;
    logic [pol_pkg::COUNT_W-1:0] count;
    logic                        last;
  } list_result_t;

  // List contents in order, head first
  logic [pol_pkg::VALUE_W-1:0] list_vals[$];
  list_result_t                expected_results[$];
  int                          fails = 0;
  int                          results_seen = 0;

  function automatic void note_failure(string msg);
    fails++;
    if (fails <= 10) $display("[%0t] %s", $realtime, msg);
  endfunction

  // Queue one result; the count field reflects the list after the operation
  function automatic void push_result(logic [pol_pkg::VALUE_W-1:0] v, pol_pkg::status_t st,
                                      logic fin);
    list_result_t r;
    r.value_out = v;
    r.status    = st;
    r.count     = pol_pkg::COUNT_W'(list_vals.size());
    r.last      = fin;
    expected_results.push_back(r);
  endfunction

  // Apply one accepted operation to the list and queue what it must return
  function automatic void apply_op(pol_pkg::mode_t m, logic [pol_pkg::VALUE_W-1:0] v,
                                   logic [pol_pkg::POS_W-1:0] p);
    int n;
    int at;
    n  = list_vals.size();
    at = (m == pol_pkg::MODE_APPEND) ? n + 1 : int'(p);
    case (m)
      pol_pkg::MODE_DUMP: begin
        if (n == 0) push_result('0, pol_pkg::ST_EMPTY, 1'b1);
        else foreach (list_vals[i]) push_result(list_vals[i], pol_pkg::ST_OK, i == n - 1);
      end
      pol_pkg::MODE_APPEND, pol_pkg::MODE_INSERT: begin
        if (n >= pol_pkg::CAPACITY) push_result('0, pol_pkg::ST_FULL, 1'b1);
        else if (at < 1 || at > n + 1) push_result('0, pol_pkg::ST_INVALID, 1'b1);
        else begin
          list_vals.insert(at - 1, v);
          push_result('0, pol_pkg::ST_OK, 1'b1);
        end
      end
      default: begin
        if (n == 0) push_result('0, pol_pkg::ST_EMPTY, 1'b1);
        else if (at < 1 || at > n) push_result('0, pol_pkg::ST_INVALID, 1'b1);
        else begin
          list_vals.delete(at - 1);
          push_result('0, pol_pkg::ST_OK, 1'b1);
        end
      end
    endcase
  endfunction

  // Compare one response transfer with the oldest expectation
  function automatic void check_result(logic [pol_pkg::VALUE_W-1:0] v,
                                       logic [pol_pkg::STATUS_W-1:0] st,
                                       logic [pol_pkg::COUNT_W-1:0] c, logic fin);
    list_result_t want;
    results_seen++;
    if (expected_results.size() == 0) begin
      note_failure($sformatf("unexpected result: value %0d status %0d count %0d last %b",
                             $signed(v), st, c, fin));
      return;
    end
    want = expected_results.pop_front();
    if (want.value_out !== v || want.status !== st || want.count !== c ||
        want.last !== fin) begin
      note_failure($sformatf({"result %0d mismatch: expected value %0d status %0d ",
                              "count %0d last %b, got value %0d status %0d count %0d last %b"},
                             results_seen, $signed(want.value_out), want.status, want.count,
                             want.last, $signed(v), st, c, fin));
    end
  endfunction

  // Track transfers on both channels
  always @(posedge clk) begin
    if (!rst) begin
      if (req_mon.valid && req_mon.ready)
        apply_op(pol_pkg::mode_t'(req_mon.mode), req_mon.value, req_mon.position);
      if (rsp_mon.valid && rsp_mon.ready)
        check_result(rsp_mon.value_out, rsp_mon.status, rsp_mon.element_count, rsp_mon.last);
    end
    fail_count   <= fails;
    pending      <= expected_results.size();
    result_count <= results_seen;
  end

endmodule

@@ verif/positional_ordered_list_tb.sv @@
`timescale 1ns / 1ps

module positional_ordered_list_tb;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 80;

  logic clk = 1'b0;
  logic rst;
  logic hold_off = 1'b0;
  int   recv_stall_pct = 0;
  int   send_idle_pct = 0;
  int   fail_count;
  int   pending;
  int   result_count;

  // Stimulus steering: length the list should have, and refused grows
  int list_len = 0;
  int full_hits = 0;
  int ops_by_mode[4] = '{default: 0};

  pol_req_if req();
  pol_rsp_if rsp();

  positional_ordered_list u_top (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  pol_list_checker u_checker (
    .clk(clk),
    .rst(rst),
    .req_mon(req),
    .rsp_mon(rsp),
    .fail_count(fail_count),
    .pending(pending),
    .result_count(result_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Response side: random stalls, or a solid hold-off when requested
  initial begin : rsp_drive
    rsp.ready = 1'b0;
    forever begin
      @(posedge clk);
      rsp.ready <= hold_off ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // End the run if it hangs
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results still expected", cycles, pending);
    $display("positional_ordered_list test failed");
    $finish;
  end

  function automatic logic [pol_pkg::VALUE_W-1:0] rand_value();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return '1;
      3: return '0;
      default: return $urandom;
    endcase
  endfunction

  // Mostly in-range positions, some out-of-range noise
  function automatic logic [pol_pkg::POS_W-1:0] pick_position(pol_pkg::mode_t m);
    int top_pos;
    top_pos = (m == pol_pkg::MODE_INSERT) ? list_len + 1 : list_len;
    if ((m == pol_pkg::MODE_INSERT || m == pol_pkg::MODE_DELETE) && top_pos > 0 &&
        $urandom_range(99) < 88)
      return pol_pkg::POS_W'($urandom_range(top_pos, 1));
    case ($urandom_range(2))
      0: return '0;
      1: return pol_pkg::POS_W'($urandom_range((1 << pol_pkg::POS_W) - 1, top_pos + 1));
      default: return pol_pkg::POS_W'($urandom);
    endcase
  endfunction

  // Offer one operation after an optional idle gap, hold it until the transfer
  task automatic send_op(pol_pkg::mode_t m, logic [pol_pkg::VALUE_W-1:0] v,
                         logic [pol_pkg::POS_W-1:0] p);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid    <= 1'b1;
    req.mode     <= m;
    req.value    <= v;
    req.position <= p;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    ops_by_mode[m]++;
    case (m)
      pol_pkg::MODE_APPEND: begin
        if (list_len < pol_pkg::CAPACITY) list_len++;
        else full_hits++;
      end
      pol_pkg::MODE_INSERT: begin
        if (list_len >= pol_pkg::CAPACITY) full_hits++;
        else if (p >= 1 && p <= list_len + 1) list_len++;
      end
      pol_pkg::MODE_DELETE: begin
        if (list_len != 0 && p >= 1 && p <= list_len) list_len--;
      end
      default: ;
    endcase
  endtask

  task automatic random_ops(int n_ops, int grow_pct);
    pol_pkg::mode_t m;
    repeat (n_ops) begin
      if ($urandom_range(99) < 10) m = pol_pkg::MODE_DUMP;
      else if ($urandom_range(99) < grow_pct)
        m = $urandom_range(1) ? pol_pkg::MODE_APPEND : pol_pkg::MODE_INSERT;
      else m = pol_pkg::MODE_DELETE;
      send_op(m, rand_value(), pick_position(m));
    end
  endtask

  initial begin : stimulus
    rst          = 1'b1;
    req.valid    = 1'b0;
    req.mode     = pol_pkg::MODE_APPEND;
    req.value    = '0;
    req.position = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Empty-list corners
    send_op(pol_pkg::MODE_DUMP, '0, '0);
    send_op(pol_pkg::MODE_DELETE, '0, 7'd1);
    send_op(pol_pkg::MODE_DELETE, '1, '1);
    send_op(pol_pkg::MODE_INSERT, 32'd5, 7'd0);
    send_op(pol_pkg::MODE_INSERT, 32'd5, 7'd2);
    // First insert becomes head, then remove the only element
    send_op(pol_pkg::MODE_INSERT, 32'h8000_0000, 7'd1);
    send_op(pol_pkg::MODE_DUMP, '0, '0);
    send_op(pol_pkg::MODE_DELETE, '0, 7'd1);
    send_op(pol_pkg::MODE_DUMP, '0, '0);
    // Build a short list through every insert path
    send_op(pol_pkg::MODE_APPEND, 32'h7FFF_FFFF, '1);
    send_op(pol_pkg::MODE_APPEND, '1, '0);
    send_op(pol_pkg::MODE_INSERT, '0, 7'd1);
    send_op(pol_pkg::MODE_INSERT, 32'h5555_5555, 7'd4);
    send_op(pol_pkg::MODE_INSERT, 32'hAAAA_AAAA, 7'd2);
    // Out-of-range positions
    send_op(pol_pkg::MODE_INSERT, 32'd1, '1);
    send_op(pol_pkg::MODE_DELETE, '0, 7'd0);
    send_op(pol_pkg::MODE_DELETE, '0, 7'd6);
    send_op(pol_pkg::MODE_DUMP, '0, '0);
    // Delete head, tail, middle
    send_op(pol_pkg::MODE_DELETE, '0, 7'd1);
    send_op(pol_pkg::MODE_DELETE, '0, 7'd4);
    send_op(pol_pkg::MODE_DELETE, '0, 7'd2);
    send_op(pol_pkg::MODE_DUMP, '0, '0);

    // Grow hard with no idling
    random_ops(60, 90);

    // Sender idles, list saturates
    send_idle_pct = 62;
    random_ops(55, 85);

    // Receiver stalls; start with a long hold-off over a large dump
    send_idle_pct = 0;
    recv_stall_pct <= 62;
    fork
      begin
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
      end
    join_none
    send_op(pol_pkg::MODE_DUMP, '0, '0);
    random_ops(54, 30);

    // Light idling on both sides, drain the list
    send_idle_pct = 11;
    recv_stall_pct <= 11;
    random_ops(50, 25);

    // Let the checker log the last transfer before waiting on its results
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d appends, %0d inserts, %0d deletes, %0d dumps; %0d grows refused on full",
             ops_by_mode[pol_pkg::MODE_APPEND], ops_by_mode[pol_pkg::MODE_INSERT],
             ops_by_mode[pol_pkg::MODE_DELETE], ops_by_mode[pol_pkg::MODE_DUMP], full_hits);
    $display("%0d results checked, %0d mismatches", result_count, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("positional_ordered_list test passed");
    end else begin
      $display("positional_ordered_list test failed");
    end
    $finish;
  end

endmodule
